// ===== rtl/button_debounce_autorepeat_core_defines.svh =====
// Assertion macros used by the result queue of the button debounce core.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BDAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`define BDAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BDAC_ASSERT(lbl, prop, msg)
`define BDAC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/bdac_pkg.sv =====
// Types and constants of the button debounce and autorepeat core.
package bdac_pkg;

  localparam int VEC_W       = 18;
  localparam int REG_W       = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int PIN_W       = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL_FLOOR = 2'd3;

  localparam logic [REG_W-1:0] RST_DEBOUNCE_TICKS        = 10'd20;
  localparam logic [REG_W-1:0] RST_FIRST_REPEAT_TICKS    = 10'd250;
  localparam logic [REG_W-1:0] RST_REPEAT_INTERVAL_START = 10'd50;
  localparam logic [REG_W-1:0] RST_REPEAT_INTERVAL_FLOOR = 10'd10;

  typedef struct packed {
    logic [REG_W-1:0] debounce_ticks;
    logic [REG_W-1:0] first_repeat_ticks;
    logic [REG_W-1:0] repeat_interval_start;
    logic [REG_W-1:0] repeat_interval_floor;
  } cfg_t;

  typedef struct packed {
    logic             last;
    logic             is_repeat;
    logic [VEC_W-1:0] buttons;
  } res_word_t;

  typedef struct packed {
    logic      rep_vld;
    logic      chg_vld;
    res_word_t rep_word;
    res_word_t chg_word;
  } push_t;

endpackage

// ===== rtl/bdac_decode.sv =====
// Pin decoder: active-low pins to the 18-bit button vector.
module bdac_decode import bdac_pkg::*; (
  input  logic [PIN_W-1:0] pb_raw_i,
  input  logic [PIN_W-1:0] pe_raw_i,
  output logic [VEC_W-1:0] vec_o
);

  logic [PIN_W-1:0] pb;
  logic [PIN_W-1:0] pe;
  logic [2:0]       idx0;
  logic [2:0]       idx1;

  always_comb begin
    pb    = ~pb_raw_i;
    pe    = ~pe_raw_i;
    idx0  = {pe[2], pb[4], pb[3]};
    idx1  = {pe[4], pb[2], pb[1]};
    vec_o = '0;
    vec_o[16] = pe[0];
    vec_o[17] = pe[1];
    if (pe[3]) begin
      vec_o[idx0] = 1'b1;
    end
    if (pb[0]) begin
      vec_o[{2'b01, idx1}] = 1'b1;
    end
  end

endmodule

// ===== rtl/bdac_engine.sv =====
// Input register, debounce and autorepeat state, and event generation.
module bdac_engine import bdac_pkg::*; #(
  parameter int TIMER_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [PIN_W-1:0] pb_i,
  input  logic [PIN_W-1:0] pe_i,
  input  logic             tick_i,
  input  cfg_t             cfg_i,
  output logic             busy_o,
  output push_t            push_o
);

  localparam int WW = (TIMER_BITS > REG_W) ? TIMER_BITS : REG_W;
  localparam logic [WW-1:0] CNT_MAX_W = (WW'(1) << TIMER_BITS) - WW'(1);

  function automatic logic [TIMER_BITS-1:0] clamp_load(input logic [REG_W-1:0] v);
    logic [WW-1:0] e;
    e = WW'(v);
    if (e > CNT_MAX_W) begin
      e = CNT_MAX_W;
    end
    return e[TIMER_BITS-1:0];
  endfunction

  logic                  vld_q;
  logic [PIN_W-1:0]      pb_q;
  logic [PIN_W-1:0]      pe_q;
  logic                  tick_q;

  logic [VEC_W-1:0]      cand_q, cand_d;
  logic [VEC_W-1:0]      stable_q, stable_d;
  logic [TIMER_BITS-1:0] db_cnt_q, db_cnt_d;
  logic                  db_run_q, db_run_d;
  logic [TIMER_BITS-1:0] rep_cnt_q, rep_cnt_d;
  logic                  rep_run_q, rep_run_d;
  logic [TIMER_BITS-1:0] int_now_q, int_now_d;

  logic [VEC_W-1:0]      now_vec;
  logic [TIMER_BITS-1:0] db_cnt_t;
  logic [TIMER_BITS-1:0] rep_cnt_t;
  logic                  rep_fire;
  logic                  chg_fire;

  bdac_decode u_decode (
    .pb_raw_i (pb_q),
    .pe_raw_i (pe_q),
    .vec_o    (now_vec)
  );

  always_comb begin
    db_cnt_t  = db_cnt_q;
    rep_cnt_t = rep_cnt_q;
    if (tick_q && db_run_q && (db_cnt_q != '0)) begin
      db_cnt_t = db_cnt_q - TIMER_BITS'(1);
    end
    if (tick_q && rep_run_q && (rep_cnt_q != '0)) begin
      rep_cnt_t = rep_cnt_q - TIMER_BITS'(1);
    end

    cand_d    = cand_q;
    db_cnt_d  = db_cnt_t;
    db_run_d  = db_run_q;
    if (now_vec != cand_q) begin
      cand_d   = now_vec;
      db_cnt_d = clamp_load(cfg_i.debounce_ticks);
      db_run_d = 1'b1;
    end

    rep_cnt_d = rep_cnt_t;
    rep_run_d = rep_run_q;
    int_now_d = int_now_q;
    stable_d  = stable_q;

    rep_fire = rep_run_q && (rep_cnt_t == '0) && (stable_q != '0);
    if (rep_fire) begin
      rep_cnt_d = int_now_q;
      if (WW'(int_now_q) > WW'(cfg_i.repeat_interval_floor)) begin
        int_now_d = int_now_q - TIMER_BITS'(1);
      end
    end

    chg_fire = db_run_d && (db_cnt_d == '0) && (cand_d != stable_q);
    if (chg_fire) begin
      if (cand_d != '0) begin
        rep_cnt_d = clamp_load(cfg_i.first_repeat_ticks);
        rep_run_d = 1'b1;
      end else begin
        rep_cnt_d = '0;
        rep_run_d = 1'b0;
      end
      int_now_d = clamp_load(cfg_i.repeat_interval_start);
      db_cnt_d  = '0;
      db_run_d  = 1'b0;
      stable_d  = cand_d;
    end

    push_o.rep_vld            = vld_q && rep_fire;
    push_o.chg_vld            = vld_q && chg_fire;
    push_o.rep_word.buttons   = stable_q;
    push_o.rep_word.is_repeat = 1'b1;
    push_o.rep_word.last      = !chg_fire;
    push_o.chg_word.buttons   = cand_d;
    push_o.chg_word.is_repeat = 1'b0;
    push_o.chg_word.last      = 1'b1;
  end

  assign busy_o = vld_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      pb_q   <= pb_i;
      pe_q   <= pe_i;
      tick_q <= tick_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      cand_q    <= '0;
      stable_q  <= '0;
      db_cnt_q  <= '0;
      db_run_q  <= 1'b0;
      rep_cnt_q <= '0;
      rep_run_q <= 1'b0;
      int_now_q <= '0;
    end else begin
      vld_q <= in_valid_i;
      if (vld_q) begin
        cand_q    <= cand_d;
        stable_q  <= stable_d;
        db_cnt_q  <= db_cnt_d;
        db_run_q  <= db_run_d;
        rep_cnt_q <= rep_cnt_d;
        rep_run_q <= rep_run_d;
        int_now_q <= int_now_d;
      end
    end
  end

endmodule

// ===== rtl/bdac_fifo.sv =====
// Result queue: takes up to two words a cycle, hands out one.
`include "button_debounce_autorepeat_core_defines.svh"
module bdac_fifo import bdac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  push_t                 push_i,
  input  logic                  m_ready_i,
  output logic                  m_valid_o,
  output res_word_t             m_word_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  res_word_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]            n_push;
  logic                  pop;
  res_word_t             first_word;
  logic [FIFO_CNT_W:0]   cnt_sum;
  logic                  head_open;
  logic                  head_chg;

  always_comb begin
    n_push     = {1'b0, push_i.rep_vld} + {1'b0, push_i.chg_vld};
    first_word = push_i.rep_vld ? push_i.rep_word : push_i.chg_word;
    pop        = m_valid_o && m_ready_i;
    wr_ptr_d   = wr_ptr_q + FIFO_PTR_W'(n_push);
    rd_ptr_d   = rd_ptr_q + FIFO_PTR_W'(pop);
    cnt_d      = cnt_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    cnt_sum    = {1'b0, cnt_q} + (FIFO_CNT_W + 1)'(n_push);
    head_open  = m_valid_o && !m_word_o.last;
    head_chg   = m_valid_o && !m_word_o.is_repeat;
  end

  assign m_valid_o = (cnt_q != '0);
  assign m_word_o  = mem_q[rd_ptr_q];
  assign count_o   = cnt_q;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= first_word;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_i.chg_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `BDAC_ASSERT(a_cnt_bound, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "result queue count out of range")
  `BDAC_ASSERT(a_no_overflow, cnt_sum <= (FIFO_CNT_W + 1)'(FIFO_DEPTH), "result queue overflow")
  `BDAC_ASSERT_IMPL(a_pair_order, head_open, m_word_o.is_repeat, "non-final word is not a repeat")
  `BDAC_ASSERT_IMPL(a_pair_follow, head_open && m_ready_i, ##1 head_chg, "unpaired repeat word")

endmodule

// ===== rtl/button_debounce_autorepeat_core.sv =====
// Top level of the button debounce and autorepeat core.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tdata: port_b_pins, port_e_pins, tick
//  m_axis   out  m_axis_tvalid/m_axis_tready    tdata: buttons; tuser: is_repeat; tlast
//  cfg      in   cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
//  A word is held in the input register while its results are formed;
//  they join an eight-word queue at the next edge, up to two per word, repeat first.
//  s_axis_tready is high while the queue plus the word in flight leave room for two.
//  With m_axis_tready held high, one word is taken every cycle while words give at
//  most one result each; a run of two-result words is held to one result a cycle.
//  Reset clears the control state and loads the register defaults; no clearing pass.
module button_debounce_autorepeat_core import bdac_pkg::*; #(
  parameter int TIMER_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // port_b_pins[4:0], port_e_pins[9:5], tick[10]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // buttons[17:0]
  output logic                   m_axis_tuser,   // is_repeat[0]
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [REG_W-1:0]       cfg_wdata_i
);

  cfg_t                  cfg_q;
  logic                  in_acc;
  logic                  busy;
  push_t                 push;
  res_word_t             head;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [FIFO_CNT_W:0]   occ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks        <= RST_DEBOUNCE_TICKS;
      cfg_q.first_repeat_ticks    <= RST_FIRST_REPEAT_TICKS;
      cfg_q.repeat_interval_start <= RST_REPEAT_INTERVAL_START;
      cfg_q.repeat_interval_floor <= RST_REPEAT_INTERVAL_FLOOR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE_TICKS:        cfg_q.debounce_ticks        <= cfg_wdata_i;
        REG_FIRST_REPEAT_TICKS:    cfg_q.first_repeat_ticks    <= cfg_wdata_i;
        REG_REPEAT_INTERVAL_START: cfg_q.repeat_interval_start <= cfg_wdata_i;
        REG_REPEAT_INTERVAL_FLOOR: cfg_q.repeat_interval_floor <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    occ           = {1'b0, fifo_cnt} + (busy ? (FIFO_CNT_W + 1)'(2) : '0);
    s_axis_tready = (occ <= (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2));
    in_acc        = s_axis_tvalid && s_axis_tready;
  end

  bdac_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_acc),
    .pb_i       (s_axis_tdata[PIN_W-1:0]),
    .pe_i       (s_axis_tdata[2*PIN_W-1:PIN_W]),
    .tick_i     (s_axis_tdata[2*PIN_W]),
    .cfg_i      (cfg_q),
    .busy_o     (busy),
    .push_o     (push)
  );

  bdac_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_word_o  (head),
    .count_o   (fifo_cnt)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - VEC_W){1'b0}}, head.buttons};
  assign m_axis_tuser = head.is_repeat;
  assign m_axis_tlast = head.last;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the button debounce and autorepeat core with its own key-state predictor.
module tb_top;
  import bdac_pkg::*;

  localparam int TIMER_BITS = 10;
  localparam int CNT_MAX    = (1 << TIMER_BITS) - 1;

  typedef struct packed {
    logic             tick;
    logic [PIN_W-1:0] pe;
    logic [PIN_W-1:0] pb;
  } pin_sample_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // port_b_pins[4:0], port_e_pins[9:5], tick[10]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // buttons[17:0]
  logic                   m_axis_tuser;        // is_repeat[0]
  logic                   m_axis_tlast;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = REG_DEBOUNCE_TICKS;
  logic [REG_W-1:0]       cfg_wdata_i   = '0;

  button_debounce_autorepeat_core #(.TIMER_BITS(TIMER_BITS)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted key state and timing registers
  cfg_t             timing = '{RST_DEBOUNCE_TICKS, RST_FIRST_REPEAT_TICKS,
                               RST_REPEAT_INTERVAL_START, RST_REPEAT_INTERVAL_FLOOR};
  logic [VEC_W-1:0] cand_vec   = '0;
  logic [VEC_W-1:0] stable_vec = '0;
  logic [REG_W-1:0] deb_cnt    = '0;
  logic             deb_run    = 1'b0;
  logic [REG_W-1:0] rep_cnt    = '0;
  logic             rep_run    = 1'b0;
  logic [REG_W-1:0] rep_ivl    = '0;

  pin_sample_t pin_samples_q[$];
  res_word_t   due_events_q[$];
  pin_sample_t word_on_bus;
  res_word_t   want;
  int          words_queued = 0;
  int          words_taken  = 0;
  int          mismatches   = 0;
  int          idle_mode    = 0;
  int          send_idle_pct[4] = '{0, 48, 0, 18};
  int          recv_idle_pct[4] = '{0, 0, 48, 18};
  logic        pressure_go   = 1'b0;
  logic        pressure_done = 1'b0;
  int          hold_left     = 0;

  function automatic logic [REG_W-1:0] sat_load(logic [REG_W-1:0] v);
    return (int'(v) > CNT_MAX) ? REG_W'(CNT_MAX) : v;
  endfunction

  function automatic logic [VEC_W-1:0] decode_keys(pin_sample_t s);
    logic [PIN_W-1:0] b;
    logic [PIN_W-1:0] e;
    logic [VEC_W-1:0] v;
    logic [2:0]       k;
    b = ~s.pb;
    e = ~s.pe;
    v = '0;
    v[16] = e[0];
    v[17] = e[1];
    if (e[3]) begin
      k = {e[2], b[4], b[3]};
      v[k] = 1'b1;
    end
    if (b[0]) begin
      k = {e[4], b[2], b[1]};
      v[8 + k] = 1'b1;
    end
    return v;
  endfunction

  function automatic void debounce_step(pin_sample_t s);
    logic [VEC_W-1:0] now_vec;
    logic [VEC_W-1:0] rep_vec;
    logic             rep_fire;
    logic             chg_fire;
    if (s.tick) begin
      if (deb_run && deb_cnt != 0) deb_cnt = deb_cnt - 1'b1;
      if (rep_run && rep_cnt != 0) rep_cnt = rep_cnt - 1'b1;
    end
    now_vec = decode_keys(s);
    if (now_vec != cand_vec) begin
      cand_vec = now_vec;
      deb_cnt  = sat_load(timing.debounce_ticks);
      deb_run  = 1'b1;
    end
    rep_vec  = stable_vec;
    rep_fire = rep_run && rep_cnt == 0 && stable_vec != 0;
    if (rep_fire) begin
      rep_cnt = rep_ivl;
      if (rep_ivl > timing.repeat_interval_floor) rep_ivl = rep_ivl - 1'b1;
    end
    chg_fire = deb_run && deb_cnt == 0 && cand_vec != stable_vec;
    if (chg_fire) begin
      rep_run    = cand_vec != 0;
      rep_cnt    = rep_run ? sat_load(timing.first_repeat_ticks) : '0;
      rep_ivl    = sat_load(timing.repeat_interval_start);
      deb_cnt    = '0;
      deb_run    = 1'b0;
      stable_vec = cand_vec;
    end
    if (rep_fire) due_events_q.push_back('{last: !chg_fire, is_repeat: 1'b1, buttons: rep_vec});
    if (chg_fire) due_events_q.push_back('{last: 1'b1, is_repeat: 1'b0, buttons: stable_vec});
  endfunction

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        debounce_step(word_on_bus);
        words_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pin_samples_q.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct[idle_mode]) begin
          word_on_bus = pin_samples_q.pop_front();
          s_axis_tdata  <= IN_TDATA_W'(word_on_bus);
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left     <= 0;
      pressure_done <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      hold_left     <= 300;
      pressure_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct[idle_mode]);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_events_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word tdata=%h", m_axis_tdata));
      end else begin
        want = due_events_q.pop_front();
        if (m_axis_tdata !== OUT_TDATA_W'(want.buttons))
          note_mismatch($sformatf("buttons %h, want %h", m_axis_tdata, want.buttons));
        if (m_axis_tuser !== want.is_repeat)
          note_mismatch($sformatf("is_repeat %b, want %b", m_axis_tuser, want.is_repeat));
        if (m_axis_tlast !== want.last)
          note_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  task automatic queue_sample(input logic [PIN_W-1:0] pb, input logic [PIN_W-1:0] pe,
                              input logic tick);
    pin_samples_q.push_back('{tick: tick, pe: pe, pb: pb});
    words_queued++;
  endtask

  task automatic set_timing(input logic [REG_W-1:0] deb, dly, ivl0, ivl_min);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DEBOUNCE_TICKS;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    cfg_idx_i   <= REG_FIRST_REPEAT_TICKS;
    cfg_wdata_i <= dly;
    @(posedge clk_i);
    cfg_idx_i   <= REG_REPEAT_INTERVAL_START;
    cfg_wdata_i <= ivl0;
    @(posedge clk_i);
    cfg_idx_i   <= REG_REPEAT_INTERVAL_FLOOR;
    cfg_wdata_i <= ivl_min;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timing = '{deb, dly, ivl0, ivl_min};
  endtask

  task automatic drain();
    while (words_taken != words_queued || due_events_q.size() != 0) @(posedge clk_i);
    // let words that raise no event clear the pipeline
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_presses(input int n, input int tick_pct);
    int          left;
    int          hold;
    int          roll;
    pin_sample_t s;
    left = n;
    while (left > 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        s.pb = PIN_W'($urandom);
        s.pe = PIN_W'($urandom);
        if (roll >= 60) begin
          s.pb = '1;
          s.pe = '1;
        end
        hold = $urandom_range(1, 24);
        repeat (hold) begin
          if (left > 0) begin
            queue_sample(s.pb, s.pe, $urandom_range(0, 99) < tick_pct);
            left--;
          end
        end
      end else begin
        // contact bounce
        hold = $urandom_range(1, 3);
        repeat (hold) begin
          if (left > 0) begin
            queue_sample(PIN_W'($urandom), PIN_W'($urandom), 1'($urandom));
            left--;
          end
        end
      end
    end
  endtask

  task automatic run_phase(input logic [REG_W-1:0] deb, dly, ivl0, ivl_min,
                           input int n, input int mode, input int tick_pct);
    set_timing(deb, dly, ivl0, ivl_min);
    idle_mode = mode;
    queue_presses(n, tick_pct);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: nothing settles
    queue_sample(5'd31, 5'd31, 1'b1);
    queue_sample(5'd30, 5'd30, 1'b1);
    queue_sample(5'd31, 5'd31, 1'b1);
    drain();

    // zero loads: keys 0, 7, 8, 15, 16 and 17, and both extremes
    set_timing('0, '0, '0, '0);
    queue_sample(5'd31, 5'd31, 1'b0);
    queue_sample(5'd31, 5'd30, 1'b1);
    queue_sample(5'd31, 5'd30, 1'b0);
    queue_sample(5'd31, 5'd29, 1'b1);
    queue_sample(5'd31, 5'd23, 1'b1);
    queue_sample(5'd7,  5'd19, 1'b1);
    queue_sample(5'd30, 5'd31, 1'b1);
    queue_sample(5'd24, 5'd15, 1'b1);
    queue_sample(5'd0,  5'd0,  1'b1);
    queue_sample(5'd0,  5'd0,  1'b0);
    queue_sample(5'd0,  5'd0,  1'b1);
    queue_sample(5'd31, 5'd31, 1'b1);
    queue_sample(5'd31, 5'd31, 1'b0);
    drain();

    run_phase(10'd2, 10'd4, 10'd6, 10'd2, 90, 0, 70);
    run_phase('0, '0, '0, '0, 80, 1, 100);
    run_phase(10'd3, 10'd6, 10'd8, 10'd3, 90, 2, 60);
    run_phase(10'd1, 10'd2, 10'd3, 10'd9, 80, 3, 80);
    pressure_go = 1'b1;
    run_phase('0, '0, '0, '0, 80, 0, 100);
    run_phase('1, '1, '1, '1, 40, 1, 100);
    run_phase('0, '1, '1, '0, 60, 0, 90);
    run_phase(10'd5, '0, '1, '1, 60, 2, 100);
    for (int p = 0; p < 6; p++) begin
      run_phase(REG_W'($urandom_range(0, 4)), REG_W'($urandom_range(0, 8)),
                REG_W'($urandom_range(0, 8)), REG_W'($urandom_range(0, 5)),
                80, p % 4, $urandom_range(40, 100));
    end
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && due_events_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
